// ===== src/ordered_list_push_front_remove_defines.svh =====
// Assertion macros used by the ordered list sequencer.
`ifndef ORDERED_LIST_PUSH_FRONT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_PUSH_FRONT_REMOVE_DEFINES_SVH

// Property that must hold on every rising clock edge outside reset.
`define OLPFR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define OLPFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OLPFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/olpfr_pkg.sv =====
// Package: sizes, codes and the cell control struct of the ordered list.
package olpfr_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int VAL_W = 32;
   localparam int RSP_CNT_W = 5;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_REMOVED   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic push;
      logic compare;
      logic scan;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== src/olpfr_cell.sv =====
// One list position: value, valid flag and the match-seen flag of a remove.
module olpfr_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  olpfr_pkg::cell_ctrl_type    ctrl,
   input  logic signed [31:0]          req_value,
   input  logic signed [31:0]          prev_val,
   input  logic                        prev_vld,
   input  logic                        prev_seen,
   input  logic signed [31:0]          next_val,
   input  logic                        next_vld,
   output logic signed [31:0]          val,
   output logic                        vld,
   output logic                        seen
);
   import olpfr_pkg::*;

   logic signed [VAL_W-1:0] val_ff, val_in;
   logic                    vld_ff, vld_in;
   logic                    seen_ff, seen_in;

   always_comb begin
      val_in  = val_ff;
      vld_in  = vld_ff;
      seen_in = seen_ff;
      if (ctrl.push) begin
         val_in = prev_val;
         vld_in = prev_vld;
      end
      if (ctrl.compare) begin
         seen_in = vld_ff && (val_ff == req_value);
      end
      if (ctrl.scan) begin
         seen_in = seen_ff | prev_seen;
      end
      if (ctrl.shift && seen_ff) begin
         val_in = next_val;
         vld_in = next_vld;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      seen_ff <= seen_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign val  = val_ff;
   assign vld  = vld_ff;
   assign seen = seen_ff;

endmodule

// ===== src/olpfr_ctrl.sv =====
// Sequencer: command handshake, entry count, remove scan and result strobe.
`include "ordered_list_push_front_remove_defines.svh"
module olpfr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        req_operation,
   input  logic                        last_seen,
   output olpfr_pkg::cell_ctrl_type    ctrl,
   output logic                        busy,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [4:0]                  rsp_entry_count
);
   import olpfr_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             accept;
   logic             full;
   logic             scan_done;

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign scan_done = (scan_cnt_ff == IDX_W'(DEPTH - 2));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_REMOVE) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_SHIFT;
         end
         ST_SHIFT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      ctrl          = '0;
      scan_cnt_in   = scan_cnt_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (accept) begin
               if (req_operation == OP_PUSH) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ctrl.push     = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = STATUS_INSERTED;
                  end
               end else begin
                  ctrl.compare = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            ctrl.scan   = 1'b1;
            scan_cnt_in = scan_cnt_ff + IDX_W'(1);
         end
         ST_SHIFT: begin
            ctrl.shift   = 1'b1;
            rsp_valid_in = 1'b1;
            if (last_seen) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_status_in = STATUS_REMOVED;
            end else begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff   <= scan_cnt_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = RSP_CNT_W'(count_ff);

   `OLPFR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "count over depth")
   `OLPFR_ASSERT_IMPL(a_no_rsp_busy, clock, reset, busy, !rsp_valid_ff, "strobe while busy")
   `OLPFR_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_FULL, count_ff == CNT_W'(DEPTH), "full flagged below depth")
   `OLPFR_ASSERT_NEXT(a_push_count, clock, reset, ctrl.push, count_ff == $past(count_ff) + CNT_W'(1), "push count step")

endmodule

// ===== src/ordered_list_push_front_remove.sv =====
// Top level: bounded ordered list with push to front and remove of first match.
//
// Usage
//   Raise start with req_operation and req_value; the transaction is taken at a
//   rising edge where start is high and busy is low. req_operation selects push
//   to front or removal of the first entry equal to req_value.
//   Each transaction gives one result: rsp_valid is high for exactly one cycle
//   with rsp_status and rsp_entry_count (entries held afterwards). The receiver
//   cannot stall; the result must be taken in that cycle.
// Timing
//   Push: result strobe in the cycle after acceptance; busy stays low, so a push
//   or remove may follow in the very next cycle.
//   Remove: busy through the scan and shift states; the result strobe comes in
//   the cycle busy falls, so the next transaction can be taken as the strobe
//   appears. The scan state carries the match flag one cell per cycle down the
//   chain, so the first match is known at the tail before the gap is closed.
// Reset
//   Synchronous, active high: list empty, count zero, no strobe pending.
module ordered_list_push_front_remove (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_entry_count
);
   import olpfr_pkg::*;

   cell_ctrl_type           ctrl;
   logic signed [VAL_W-1:0] cell_val  [DEPTH];
   logic                    cell_vld  [DEPTH];
   logic                    cell_seen [DEPTH];

   // Sequencer: handshake, count and result.
   olpfr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_operation   (req_operation),
      .last_seen       (cell_seen[DEPTH-1]),
      .ctrl            (ctrl),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Chain of cells; position 0 is the front. A push advances every cell one
   // place back, a remove pulls cells at and behind the first match forward.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] prev_val, next_val;
      logic                    prev_vld, next_vld, prev_seen;

      if (i == 0) begin : g_front
         assign prev_val  = req_value;
         assign prev_vld  = 1'b1;
         assign prev_seen = 1'b0;
      end else begin : g_mid
         assign prev_val  = cell_val[i-1];
         assign prev_vld  = cell_vld[i-1];
         assign prev_seen = cell_seen[i-1];
      end

      // Drop a zero invalid entry into the tail when the gap closes.
      if (i == DEPTH - 1) begin : g_tail
         assign next_val = '0;
         assign next_vld = 1'b0;
      end else begin : g_body
         assign next_val = cell_val[i+1];
         assign next_vld = cell_vld[i+1];
      end

      olpfr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .req_value (req_value),
         .prev_val  (prev_val),
         .prev_vld  (prev_vld),
         .prev_seen (prev_seen),
         .next_val  (next_val),
         .next_vld  (next_vld),
         .val       (cell_val[i]),
         .vld       (cell_vld[i]),
         .seen      (cell_seen[i])
      );
   end

endmodule

// ===== dv/ordered_list_push_front_remove_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bounded ordered list with push to front and remove of first match.
module ordered_list_push_front_remove_tb;
   import olpfr_pkg::*;

   localparam int CLK_HALF     = 4;
   // Slowest correct run: about 575 transactions, even if all were removes with
   // idle gaps, ends well before this limit, so this leaves a wide margin.
   localparam int CYCLE_LIMIT  = 200000;
   // Drain for longer than a remove holds busy, so any stray strobe is still caught.
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam int PHASE_LEN    = 40;

   typedef struct {
      status_type           status;
      logic [RSP_CNT_W-1:0] entry_count;
   } list_result_type;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      start         = 1'b0;
   logic                      req_operation = OP_PUSH;
   logic signed [VAL_W-1:0]   req_value     = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [4:0]                rsp_entry_count;

   // Shadow copy of the list contents, front of the list at index 0.
   logic signed [VAL_W-1:0]   list_entries[$];
   // Results predicted for accepted transactions, oldest first.
   list_result_type           expected_results[$];
   list_result_type           oldest_result;

   int error_count  = 0;
   int cycle_count  = 0;
   int push_count   = 0;
   int remove_count = 0;
   int full_count   = 0;
   int miss_count   = 0;
   int peak_fill    = 0;

   ordered_list_push_front_remove i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Apply one accepted transaction to the shadow list and queue its result.
   task automatic predict_list_update(input logic op, input logic signed [VAL_W-1:0] val);
      list_result_type res;
      int              hit;
      hit = -1;
      if (op == OP_PUSH) begin
         push_count++;
         if (list_entries.size() >= DEPTH) begin
            // Full list: drop the push, leave contents and count alone
            res.status = STATUS_FULL;
            full_count++;
         end else begin
            list_entries.push_front(val);
            res.status = STATUS_INSERTED;
         end
      end else begin
         remove_count++;
         // Search from the front; only the nearest duplicate goes
         foreach (list_entries[i]) begin
            if (hit < 0 && list_entries[i] == val) hit = i;
         end
         if (hit < 0) begin
            res.status = STATUS_NOT_FOUND;
            miss_count++;
         end else begin
            list_entries.delete(hit);
            res.status = STATUS_REMOVED;
         end
      end
      res.entry_count = RSP_CNT_W'(list_entries.size());
      if (list_entries.size() > peak_fill) peak_fill = list_entries.size();
      expected_results.push_back(res);
   endtask

   // Present one transaction and hold it until the block takes it.
   // Leave start high afterwards so that a following call runs back to back.
   task automatic send_transaction(input logic op, input logic signed [VAL_W-1:0] val);
      req_operation <= op;
      req_value     <= val;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      predict_list_update(op, val);
   endtask

   // Drop start for a burst of cycles, with junk on the request fields.
   task automatic idle_cycles(input int n);
      start         <= 1'b0;
      req_operation <= 1'($urandom_range(0, 1));
      req_value     <= $urandom();
      repeat (n) @(posedge clock);
   endtask

   // Half small values so that duplicates and matches are common; the rest
   // covers extremes, single bits set or cleared and fully random words.
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 7))
         0, 1, 2, 3: v = VAL_W'(int'($urandom_range(0, 8)) - 4);
         4:          v = $urandom();
         5: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = '0;
               default: v = -32'sd1;
            endcase
         end
         6:          v = 32'sd1 <<< $urandom_range(0, 31);
         default:    v = ~(32'sd1 <<< $urandom_range(0, 31));
      endcase
      return v;
   endfunction

   task automatic test_remove_on_empty();
      // Nothing held yet: every remove must miss and leave the count at zero
      send_transaction(OP_REMOVE, 32'sd0);
      send_transaction(OP_REMOVE, 32'sh8000_0000);
   endtask

   task automatic test_fill_and_overflow();
      logic signed [VAL_W-1:0] fill_set[8];
      fill_set = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                   32'sd5, -32'sd5, 32'sd7, 32'sd7};
      // Fill to capacity; the table wraps, so every value is held at least twice
      for (int i = 0; i < DEPTH; i++) begin
         send_transaction(OP_PUSH, fill_set[i % 8]);
      end
      // Push past capacity: both must be dropped and flagged
      send_transaction(OP_PUSH, 32'sh7FFF_FFFF);
      send_transaction(OP_PUSH, 32'sh8000_0000);
   endtask

   task automatic test_remove_cases();
      // Same magnitude, opposite sign: the compare covers all 32 bits
      send_transaction(OP_REMOVE, -32'sd7);
      // Duplicate value: only the copy nearest the front goes
      send_transaction(OP_REMOVE, 32'sd7);
      // First value pushed is held twice; the copy nearer the front goes
      send_transaction(OP_REMOVE, 32'sh8000_0000);
      // The front now holds the push before the most recent one, also a 7
      send_transaction(OP_REMOVE, 32'sd7);
   endtask

   // Random traffic in alternating fill-heavy and drain-heavy phases, so the
   // list swings between empty and full. Removes mostly target held values.
   task automatic test_random_traffic(input int n, input bit with_gaps);
      int                      push_pct;
      logic                    op;
      logic signed [VAL_W-1:0] val;
      push_pct = 80;
      for (int k = 0; k < n; k++) begin
         if (k % PHASE_LEN == 0) push_pct = ((k / PHASE_LEN) % 2 == 0) ? 80 : 25;
         op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_REMOVE;
         if (op == OP_REMOVE && list_entries.size() != 0 && $urandom_range(0, 9) < 7)
            val = list_entries[$urandom_range(0, list_entries.size() - 1)];
         else
            val = pick_value();
         // About one transaction in four follows a burst of idle cycles
         if (with_gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 9));
         send_transaction(op, val);
      end
   endtask

   // Check every strobe against the oldest prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d entry_count %0d",
                     $time, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_status !== oldest_result.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, oldest_result.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== oldest_result.entry_count) begin
               $display("%0t: entry_count mismatch: expected %0d actual %0d",
                        $time, oldest_result.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      // Hold reset from time zero, then release it once
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_remove_on_empty();
      test_fill_and_overflow();
      test_remove_cases();
      test_random_traffic(450, 1'b1);
      // Final stretch with no idling at all
      test_random_traffic(100, 1'b0);
      start <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d pushes (%0d dropped on a full list) and %0d removes (%0d missed).",
               push_count, full_count, remove_count, miss_count);
      $display("Highest fill seen: %0d of %0d entries.", peak_fill, DEPTH);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
